/* hdl/lzwc_pkg.sv */
//------------------------------------------------------------------------------
// LZW compressor package
// Shared widths, constants and the controller state type.
//------------------------------------------------------------------------------
`default_nettype none

package lzwc_pkg;

   // Payload widths
   localparam int BYTE_W = 8;
   localparam int CODE_W = 12;

   // First code handed out to a learned pair
   localparam int FIRST_FREE = 257;

   // Width of the stream epoch stored with each hash table entry
   localparam int EPOCH_W = 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_EMIT_MISS,
      ST_EMIT_FINAL
   } lzwc_state_type;

endpackage : lzwc_pkg

`default_nettype wire

/* hdl/lzwc_req_if.sv */
//------------------------------------------------------------------------------
// LZW compressor request channel
// Valid/ready channel carrying one raw byte and its end-of-stream flag.
//------------------------------------------------------------------------------
`default_nettype none

interface lzwc_req_if;
   logic                        valid;
   logic                        ready;
   logic [lzwc_pkg::BYTE_W-1:0] data_byte;
   logic                        final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface : lzwc_req_if

`default_nettype wire

/* hdl/lzwc_rsp_if.sv */
//------------------------------------------------------------------------------
// LZW compressor response channel
// Valid/ready channel carrying one emitted code and its last-code flag.
//------------------------------------------------------------------------------
`default_nettype none

interface lzwc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lzwc_pkg::CODE_W-1:0] out_code;
   logic                        last_code;

   modport source (output valid, output out_code, output last_code, input ready);
   modport sink   (input valid, input out_code, input last_code, output ready);
endinterface : lzwc_rsp_if

`default_nettype wire

/* hdl/lzwc_ram.sv */
//------------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
//------------------------------------------------------------------------------
`default_nettype none

module lzwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : lzwc_ram

`default_nettype wire

/* hdl/lzw_compressor.sv */
// Flow: a byte after the root prefix is absorbed without a table read; otherwise
//   the byte is accepted, the table is probed row by row, and a miss emits a code.
// Bytes: a new byte is taken only in idle, after the probe loop on the single read
//   port of the hash table RAM (linear probing, load below one half) and any emit.
// Reset: a clearing pass writes every one of the 2**($clog2(CODE_LIMIT)+1) table
//   rows (8192 by default); it repeats after every 255 streams.
//------------------------------------------------------------------------------
// LZW compressor top level
// Streaming LZW encoder; the dictionary is a hashed table of (prefix, byte)
// pairs in one RAM, tagged with a stream epoch so a new stream starts empty.
//------------------------------------------------------------------------------
`default_nettype none

module lzw_compressor #(
   parameter int CODE_LIMIT = 4096
) (
   input wire logic    clock,
   input wire logic    reset,
   lzwc_req_if.sink    req_chan,
   lzwc_rsp_if.source  rsp_chan
);

   localparam int BW    = lzwc_pkg::BYTE_W;
   localparam int OW    = lzwc_pkg::CODE_W;
   localparam int EW    = lzwc_pkg::EPOCH_W;
   localparam int CW    = $clog2(CODE_LIMIT);
   localparam int NW    = $clog2(CODE_LIMIT + 1);
   localparam int AW    = CW + 1;
   localparam int DEPTH = 2 ** AW;
   localparam int RW    = EW + CW + BW + CW;
   localparam int XW    = CW + OW;

   // Registers
   lzwc_pkg::lzwc_state_type state_ff, state_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic          fin_ff, fin_in;
   logic [CW-1:0] prefix_ff, prefix_in;
   logic [NW-1:0] next_code_ff, next_code_in;
   logic [EW-1:0] epoch_ff, epoch_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_code_ff, rsp_code_in;
   logic          rsp_last_ff, rsp_last_in;

   // RAM ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [RW-1:0] rd_data;

   // Decoded table row: {epoch, prefix, byte, code}
   logic [EW-1:0] rd_epoch;
   logic [CW-1:0] rd_prefix;
   logic [BW-1:0] rd_byte;
   logic [CW-1:0] rd_code;

   logic [AW-1:0] req_hash;
   logic [CW-1:0] req_byte_code;
   logic [CW-1:0] held_byte_code;
   logic [XW-1:0] prefix_ext;
   logic          slot_free;
   logic          dict_room;
   logic          row_match;
   logic          row_empty;

   // Hash of a (prefix, byte) pair into a table address
   function automatic logic [AW-1:0] pair_hash(input logic [CW-1:0] pfx,
                                               input logic [BW-1:0] b);
      logic [AW-1:0] h;
      h = AW'(pfx) ^ {b, {(AW-BW){1'b0}}} ^ AW'(b);
      return h;
   endfunction

   assign rd_epoch  = rd_data[RW-1 -: EW];
   assign rd_prefix = rd_data[CW+BW+CW-1 -: CW];
   assign rd_byte   = rd_data[CW+BW-1 -: BW];
   assign rd_code   = rd_data[CW-1:0];

   assign req_hash       = pair_hash(prefix_ff, req_chan.data_byte);
   assign req_byte_code  = CW'(req_chan.data_byte) + CW'(1);
   assign held_byte_code = CW'(byte_ff) + CW'(1);
   assign prefix_ext     = XW'(prefix_ff);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign dict_room      = next_code_ff < NW'(CODE_LIMIT);
   assign row_match      = (rd_epoch == epoch_ff) && (rd_prefix == prefix_ff) &&
                           (rd_byte == byte_ff);
   assign row_empty      = (rd_epoch != epoch_ff);

   // Channel outputs
   assign req_chan.ready     = (state_ff == lzwc_pkg::ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_code  = rsp_code_ff;
   assign rsp_chan.last_code = rsp_last_ff;

   // Hash table
   lzwc_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      fin_in       = fin_ff;
      prefix_in    = prefix_ff;
      next_code_in = next_code_ff;
      epoch_in     = epoch_ff;
      addr_in      = addr_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;

      case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            // Sweep: epoch zero marks a row as empty
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               state_in = lzwc_pkg::ST_IDLE;
               epoch_in = EW'(1);
            end
         end

         lzwc_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               byte_in = req_chan.data_byte;
               fin_in  = req_chan.final_byte;
               if (prefix_ff == '0) begin
                  // Root prefix always matches the byte's own code
                  prefix_in = req_byte_code;
                  state_in  = req_chan.final_byte ? lzwc_pkg::ST_EMIT_FINAL
                                                  : lzwc_pkg::ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req_hash;
                  addr_in  = req_hash;
                  state_in = lzwc_pkg::ST_PROBE;
               end
            end
         end

         lzwc_pkg::ST_PROBE: begin
            if (row_match) begin
               prefix_in = rd_code;
               state_in  = fin_ff ? lzwc_pkg::ST_EMIT_FINAL : lzwc_pkg::ST_IDLE;
            end else if (row_empty) begin
               // Miss: learn the pair here unless the dictionary is full
               if (dict_room) begin
                  wr_en        = 1'b1;
                  wr_addr      = addr_ff;
                  wr_data      = {epoch_ff, prefix_ff, byte_ff, next_code_ff[CW-1:0]};
                  next_code_in = next_code_ff + NW'(1);
               end
               state_in = lzwc_pkg::ST_EMIT_MISS;
            end else begin
               // Row holds another pair: probe the next one
               rd_en   = 1'b1;
               rd_addr = addr_ff + AW'(1);
               addr_in = addr_ff + AW'(1);
            end
         end

         lzwc_pkg::ST_EMIT_MISS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = prefix_ext[OW-1:0];
               rsp_last_in  = 1'b0;
               prefix_in    = held_byte_code;
               state_in     = fin_ff ? lzwc_pkg::ST_EMIT_FINAL : lzwc_pkg::ST_IDLE;
            end
         end

         lzwc_pkg::ST_EMIT_FINAL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = prefix_ext[OW-1:0];
               rsp_last_in  = 1'b1;
               prefix_in    = '0;
               next_code_in = NW'(lzwc_pkg::FIRST_FREE);
               // New stream: bump the epoch, or wipe the table when it wraps
               if (epoch_ff == '1) begin
                  clr_addr_in = '0;
                  state_in    = lzwc_pkg::ST_CLEAR;
               end else begin
                  epoch_in = epoch_ff + EW'(1);
                  state_in = lzwc_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            clr_addr_in = '0;
            state_in    = lzwc_pkg::ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzwc_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         epoch_ff     <= EW'(1);
         prefix_ff    <= '0;
         next_code_ff <= NW'(lzwc_pkg::FIRST_FREE);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         epoch_ff     <= epoch_in;
         prefix_ff    <= prefix_in;
         next_code_ff <= next_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      fin_ff      <= fin_in;
      addr_ff     <= addr_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule : lzw_compressor

`default_nettype wire

/* hdl/lzwc_checker.sv */
//------------------------------------------------------------------------------
// LZW compressor port checker
// Watches the top level's channels and flags handshake or sequencing slips.
//------------------------------------------------------------------------------
`default_nettype none

module lzwc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        req_final,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [lzwc_pkg::CODE_W-1:0] rsp_code,
   input wire logic                        rsp_last
);

   // A stalled response transaction keeps its payload
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code) && $stable(rsp_last))
      else $error("response changed while stalled");

   // Reset starts the table clearing pass, so no byte is taken right after it
   reset_clear_a: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // A final byte always leaves work (a code to emit), so ready drops
   final_busy_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final |=> !req_ready)
      else $error("request ready right after a final byte");

   // No response is valid as the clearing pass after reset begins
   reset_quiet_a: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule : lzwc_checker

bind lzw_compressor lzwc_checker u_lzwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_final (req_chan.final_byte),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_code  (rsp_chan.out_code),
   .rsp_last  (rsp_chan.last_code)
);

`default_nettype wire
